FILE: design/pht_pkg.sv
// ---------------------------------------------------------------------------
// pht_pkg: shared types and constants of the page hotness tracker
// Sizes of the page table, the counter width, register map and codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

	// sizing
	localparam int NUM_PAGES   = 4096;
	localparam int PAGE_SHIFT  = 21;
	localparam int COUNT_WIDTH = 16;
	localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int ADDR_W      = 48;
	localparam int PID_W       = 22;
	localparam int THR_W       = 16;
	localparam int EPOCH_W     = 32;
	localparam int REQ_PAGE_W  = 12;
	localparam int SUM_W       = COUNT_WIDTH + 1;
	localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int SHAMT_W     = $clog2(COUNT_WIDTH);

	// APB register map (8-byte stride, one 64-bit word per register)
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam logic [1:0] REG_OWN_PID     = 2'd0;
	localparam logic [1:0] REG_REGION_BASE = 2'd1;
	localparam logic [1:0] REG_HOT_THR     = 2'd2;
	localparam logic [1:0] REG_COOL_THR    = 2'd3;

	// item function codes
	localparam logic [1:0] FN_SAMPLE = 2'd0;
	localparam logic [1:0] FN_MAP    = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;
	localparam logic [1:0] FN_DONE   = 2'd3;

	// migration request codes
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_HOT  = 2'd1;
	localparam logic [1:0] REQ_COLD = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [PID_W-1:0]  own_pid;
		logic [ADDR_W-1:0] region_base;
		logic [THR_W-1:0]  hot_thr;
		logic [THR_W-1:0]  cool_thr;
	} cfg_t;

	// one page table entry
	typedef struct packed {
		logic                   mapped;
		logic                   pending;
		logic                   pend_hot;
		logic                   hot;
		logic [EPOCH_W-1:0]     epoch;
		logic [COUNT_WIDTH-1:0] far_cnt;
		logic [COUNT_WIDTH-1:0] near_cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// lazy decay: shift right by the epoch gap, cleared once the gap reaches the width
	function automatic logic [COUNT_WIDTH-1:0] decay(input logic [COUNT_WIDTH-1:0] v,
			input logic [EPOCH_W-1:0] diff);
		logic [COUNT_WIDTH-1:0] r;
		if (diff >= EPOCH_W'(COUNT_WIDTH)) begin
			r = '0;
		end else begin
			r = v >> diff[SHAMT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/pht_ram.sv
// ---------------------------------------------------------------------------
// pht_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                         wdata,
	input  wire                                     re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/pht_cfg.sv
// ---------------------------------------------------------------------------
// pht_cfg: APB configuration registers
// Holds process id, region base and the two thresholds; pready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pht_cfg
	import pht_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:3];

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.own_pid     <= '0;
			cfg.region_base <= '0;
			cfg.hot_thr     <= THR_W'(8);
			cfg.cool_thr    <= THR_W'(18);
		end else if (wr_en) begin
			case (reg_idx)
				REG_OWN_PID:     cfg.own_pid     <= pwdata[PID_W-1:0];
				REG_REGION_BASE: cfg.region_base <= pwdata[ADDR_W-1:0];
				REG_HOT_THR:     cfg.hot_thr     <= pwdata[THR_W-1:0];
				REG_COOL_THR:    cfg.cool_thr    <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (reg_idx)
			REG_OWN_PID:     prdata = PDATA_W'(cfg.own_pid);
			REG_REGION_BASE: prdata = PDATA_W'(cfg.region_base);
			REG_HOT_THR:     prdata = PDATA_W'(cfg.hot_thr);
			REG_COOL_THR:    prdata = PDATA_W'(cfg.cool_thr);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/page_hotness_tracker_unit.sv
// ---------------------------------------------------------------------------
// page_hotness_tracker_unit: per-page read hotness tracker with lazy decay
// Counts sampled near/far reads per page, raises hot/cold migration requests.
// ---------------------------------------------------------------------------
// After reset the block sweeps its page table to zero, one entry per cycle, and
// holds busy high until all NUM_PAGES (4096) entries are cleared; configuration
// writes are taken during that time. An item is taken when start is high and
// busy is low: the page entry is read from the page-table memory in the accept
// cycle, updated in the CALC state and written back in the WB state, so busy
// stays high through CALC and WB after an accept. Every item gives one result,
// marked by done, which is registered from the WB state; done lasts one cycle and
// cannot be held off, so the receiver must take it then. Items may be offered
// again in the cycle done is high. epoch always shows the current global epoch.
`timescale 1ns / 1ps
`default_nettype none

module page_hotness_tracker_unit
	import pht_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire [PADDR_W-1:0]     paddr,
	input  wire [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	// items
	input  wire                   start,
	output logic                  busy,
	input  wire [1:0]             func,
	input  wire [ADDR_W-1:0]      addr,
	input  wire [PID_W-1:0]       proc_id,
	input  wire                   source,
	// results
	output logic                  done,
	output logic [1:0]            request,
	output logic [REQ_PAGE_W-1:0] request_page,
	output logic                  attributed,
	output logic                  cooled,
	output logic [EPOCH_W-1:0]    epoch
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	cfg_t cfg;

	logic [1:0]         state_q;
	logic [PAGE_W-1:0]  clr_q;
	logic [EPOCH_W-1:0] global_epoch_q;
	logic               done_q;
	logic [1:0]         request_q;
	logic [REQ_PAGE_W-1:0] request_page_q;
	logic               attributed_q;
	logic               cooled_q;

	logic accept;

	// accept-cycle address decode
	logic [ADDR_W-1:0] off_c;
	logic              inreg_c;
	logic [PAGE_W-1:0] pg_c;

	// stage 1: item registers, held until the next accept
	logic [1:0]        func_s1;
	logic              src_s1;
	logic [PAGE_W-1:0] pg_s1;
	logic              inreg_s1;
	logic              pid_ok_s1;
	logic              addr_nz_s1;

	// modify stage
	logic                   [ENTRY_W-1:0] rd_data;
	entry_t                 rd_entry;
	entry_t                 nxt_entry;
	logic                   samp_c;
	logic [COUNT_WIDTH-1:0] cnt_old;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] near1;
	logic [COUNT_WIDTH-1:0] far1;
	logic [CMP_W-1:0]       sum_c;
	logic [1:0]             req_c;

	// stage 2: updated entry before decay
	entry_t             entry_s2;
	logic [EPOCH_W-1:0] diff_s2;
	logic               samp_s2;
	logic [1:0]         req_s2;
	logic               we_s2;

	// write-back stage
	entry_t                 wb_entry;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic                   cool_c;

	// memory port
	logic               ram_we;
	logic [PAGE_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	pht_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	// page index of the item address
	assign off_c   = addr - cfg.region_base;
	assign inreg_c = (addr >= cfg.region_base) && ((off_c >> PAGE_SHIFT) < ADDR_W'(NUM_PAGES));
	assign pg_c    = off_c[PAGE_SHIFT +: PAGE_W];

	// sequencer and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_WB;
				ST_WB:   state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func;
			src_s1     <= source;
			pg_s1      <= pg_c;
			inreg_s1   <= inreg_c;
			pid_ok_s1  <= (proc_id == cfg.own_pid);
			addr_nz_s1 <= |addr;
		end
	end

	pht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_PAGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pg_c),
		.rdata (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	// modify: count, hot/cold decision, flag maintenance
	assign samp_c  = (func_s1 == FN_SAMPLE) && inreg_s1 && pid_ok_s1 && addr_nz_s1
		&& rd_entry.mapped;
	assign cnt_old = src_s1 ? rd_entry.far_cnt : rd_entry.near_cnt;
	assign cnt_inc = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
	assign near1   = src_s1 ? rd_entry.near_cnt : cnt_inc;
	assign far1    = src_s1 ? cnt_inc : rd_entry.far_cnt;
	assign sum_c   = CMP_W'(near1) + CMP_W'(far1);

	always_comb begin
		nxt_entry = rd_entry;
		req_c     = REQ_NONE;
		case (func_s1)
			FN_SAMPLE: begin
				if (samp_c) begin
					nxt_entry.near_cnt = near1;
					nxt_entry.far_cnt  = far1;
					nxt_entry.epoch    = global_epoch_q;
					if (sum_c >= CMP_W'(cfg.hot_thr)) begin
						if (!rd_entry.hot && !rd_entry.pending) begin
							nxt_entry.pending  = 1'b1;
							nxt_entry.pend_hot = 1'b1;
							req_c              = REQ_HOT;
						end
					end else if (rd_entry.hot && !rd_entry.pending) begin
						nxt_entry.pending  = 1'b1;
						nxt_entry.pend_hot = 1'b0;
						req_c              = REQ_COLD;
					end
				end
			end
			FN_MAP: begin
				if (!rd_entry.mapped) begin
					nxt_entry.mapped   = 1'b1;
					nxt_entry.hot      = 1'b0;
					nxt_entry.near_cnt = '0;
					nxt_entry.far_cnt  = '0;
					nxt_entry.epoch    = global_epoch_q;
				end
			end
			FN_REMOVE: begin
				nxt_entry.mapped   = 1'b0;
				nxt_entry.hot      = 1'b0;
				nxt_entry.near_cnt = '0;
				nxt_entry.far_cnt  = '0;
			end
			FN_DONE: begin
				if (rd_entry.pending) begin
					nxt_entry.pending = 1'b0;
					nxt_entry.hot     = rd_entry.pend_hot & rd_entry.mapped;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			entry_s2 <= nxt_entry;
			diff_s2  <= global_epoch_q - rd_entry.epoch;
			samp_s2  <= samp_c;
			req_s2   <= req_c;
			we_s2    <= inreg_s1;
		end
	end

	// write back: lazy decay and cooling check
	always_comb begin
		wb_entry = entry_s2;
		if (samp_s2) begin
			wb_entry.near_cnt = decay(entry_s2.near_cnt, diff_s2);
			wb_entry.far_cnt  = decay(entry_s2.far_cnt, diff_s2);
		end
	end

	assign cnt_dec = src_s1 ? wb_entry.far_cnt : wb_entry.near_cnt;
	assign cool_c  = samp_s2 && (CMP_W'(cnt_dec) > CMP_W'(cfg.cool_thr));

	// memory write: sweep after reset, else write-back of the item
	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_WB) && we_s2;
			ram_waddr = pg_s1;
			ram_wdata = wb_entry;
		end
	end

	// global epoch and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_epoch_q <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WB);
			if ((state_q == ST_WB) && cool_c) begin
				global_epoch_q <= global_epoch_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WB) begin
			request_q      <= req_s2;
			request_page_q <= (req_s2 != REQ_NONE) ? REQ_PAGE_W'(pg_s1) : '0;
			attributed_q   <= samp_s2;
			cooled_q       <= cool_c;
		end
	end

	assign done         = done_q;
	assign request      = request_q;
	assign request_page = request_page_q;
	assign attributed   = attributed_q;
	assign cooled       = cooled_q;
	assign epoch        = global_epoch_q;

	// every accepted item is followed by its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing after accept");

	// a migration request only comes from a counted sample
	a_request_attributed: assert property (@(posedge clk) disable iff (!arst_n)
		done && (request != REQ_NONE) |-> attributed)
		else $error("request without attributed sample");

	// the epoch moves by one exactly when cooling is reported
	a_epoch_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(arst_n) |-> epoch == (cooled ? EPOCH_W'($past(global_epoch_q) + 1'b1)
			: $past(global_epoch_q)))
		else $error("epoch step does not match cooled flag");

	// cooling needs a counted sample
	a_cool_attributed: assert property (@(posedge clk) disable iff (!arst_n)
		done && cooled |-> attributed)
		else $error("cooling without attributed sample");

endmodule

`default_nettype wire

FILE: sim/page_hotness_tracker_unit_tb.sv
// ---------------------------------------------------------------------------
// page_hotness_tracker_unit_tb: self-checking bench for the page hotness tracker
// Each accepted command runs through a behavioural copy of the page table.
// The copy gives the expected migration request, page, attribution, cooling and
// epoch unless a typed directed row gives its own, and each done strobe is
// compared against the oldest waiting entry. The bench opens with a short
// table of directed commands, then runs randomised phases, each with its own
// register settings and its own small set of working pages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_hotness_tracker_unit_tb;
	import pht_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 275;
	localparam int WORK_PAGES  = 8;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [1:0]            request;
		logic [REQ_PAGE_W-1:0] page;
		logic                  attributed;
		logic                  cooled;
		logic [EPOCH_W-1:0]    epoch;
	} outcome_t;

	// one line of the directed plan: a command or a register write
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  code;
		logic [63:0] val;
		logic [21:0] pid;
		bit          src;
		bit          typed;
		outcome_t    want;
	} row_t;

	localparam outcome_t QUIET = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  start;
	logic                  busy;
	logic [1:0]            func;
	logic [ADDR_W-1:0]     addr;
	logic [PID_W-1:0]      proc_id;
	logic                  source;
	logic                  done;
	logic [1:0]            request;
	logic [REQ_PAGE_W-1:0] request_page;
	logic                  attributed;
	logic                  cooled;
	logic [EPOCH_W-1:0]    epoch;

	// register mirror
	bit [PID_W-1:0]   own_pid_q  = '0;
	bit [ADDR_W-1:0]  base_q     = '0;
	bit [THR_W-1:0]   hot_thr_q  = 16'd8;
	bit [THR_W-1:0]   cool_thr_q = 16'd18;

	// page table mirror
	bit [COUNT_WIDTH-1:0] near_q   [NUM_PAGES];
	bit [COUNT_WIDTH-1:0] far_q    [NUM_PAGES];
	bit [EPOCH_W-1:0]     pg_ep_q  [NUM_PAGES];
	bit                   hot_q    [NUM_PAGES];
	bit                   pend_q   [NUM_PAGES];
	bit                   pend_hot_q [NUM_PAGES];
	bit                   mapped_q [NUM_PAGES];
	bit [EPOCH_W-1:0]     glob_ep_q = '0;

	outcome_t outcome_q[$];
	row_t     plan[$];
	int       errors     = 0;
	int       cycles     = 0;
	int       burst_left = 0;

	page_hotness_tracker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .addr(addr),
		.proc_id(proc_id), .source(source),
		.done(done), .request(request), .request_page(request_page),
		.attributed(attributed), .cooled(cooled), .epoch(epoch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// decay a counter by the epoch gap; a gap of the full width or more clears it
	function automatic bit [COUNT_WIDTH-1:0] cool_down(bit [COUNT_WIDTH-1:0] v,
			bit [EPOCH_W-1:0] gap);
		if (gap >= COUNT_WIDTH)
			return '0;
		return v >> gap;
	endfunction

	// page table update for one accepted command; returns what done should show
	function automatic outcome_t track_item(logic [1:0] f, logic [ADDR_W-1:0] a,
			logic [PID_W-1:0] pid, bit src);
		outcome_t             o;
		logic [ADDR_W-1:0]    rel;
		bit                   inreg;
		int                   pg;
		bit [COUNT_WIDTH:0]   sum;
		bit [EPOCH_W-1:0]     gap;
		bit [COUNT_WIDTH-1:0] hit;
		o = '0;
		rel = a - base_q;
		inreg = (a >= base_q) && (rel[ADDR_W-1:PAGE_SHIFT] < NUM_PAGES);
		pg = int'(rel[PAGE_SHIFT +: PAGE_W]);
		case (f)
			FN_SAMPLE: begin
				if (a != '0 && pid == own_pid_q && inreg && mapped_q[pg]) begin
					o.attributed = 1'b1;
					if (src) begin
						if (far_q[pg] != CNT_MAX)
							far_q[pg]++;
					end else begin
						if (near_q[pg] != CNT_MAX)
							near_q[pg]++;
					end
					// request decision on the count before decay
					sum = near_q[pg] + far_q[pg];
					if (sum >= hot_thr_q) begin
						if (!hot_q[pg] && !pend_q[pg]) begin
							pend_q[pg] = 1'b1;
							pend_hot_q[pg] = 1'b1;
							o.request = REQ_HOT;
							o.page = pg[REQ_PAGE_W-1:0];
						end
					end else if (hot_q[pg] && !pend_q[pg]) begin
						pend_q[pg] = 1'b1;
						pend_hot_q[pg] = 1'b0;
						o.request = REQ_COLD;
						o.page = pg[REQ_PAGE_W-1:0];
					end
					gap = glob_ep_q - pg_ep_q[pg];
					near_q[pg] = cool_down(near_q[pg], gap);
					far_q[pg] = cool_down(far_q[pg], gap);
					pg_ep_q[pg] = glob_ep_q;
					hit = src ? far_q[pg] : near_q[pg];
					if (hit > cool_thr_q) begin
						glob_ep_q++;
						o.cooled = 1'b1;
					end
				end
			end
			FN_MAP: begin
				if (inreg && !mapped_q[pg]) begin
					mapped_q[pg] = 1'b1;
					hot_q[pg] = 1'b0;
					near_q[pg] = '0;
					far_q[pg] = '0;
					pg_ep_q[pg] = glob_ep_q;
				end
			end
			FN_REMOVE: begin
				if (inreg) begin
					mapped_q[pg] = 1'b0;
					hot_q[pg] = 1'b0;
					near_q[pg] = '0;
					far_q[pg] = '0;
				end
			end
			default: begin
				if (inreg && pend_q[pg]) begin
					pend_q[pg] = 1'b0;
					hot_q[pg] = pend_hot_q[pg] & mapped_q[pg];
				end
			end
		endcase
		o.epoch = glob_ep_q;
		return o;
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(int pg, int off);
		return base_q + (ADDR_W'(pg) << PAGE_SHIFT) + ADDR_W'(off);
	endfunction

	// present one command; bursts of back-to-back offers with random gaps between
	task automatic offer(logic [1:0] f, logic [ADDR_W-1:0] a, logic [PID_W-1:0] pid,
			bit src, bit typed, outcome_t want);
		int       gap;
		outcome_t o;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			@(negedge clk) start <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		addr <= a;
		proc_id <= pid;
		source <= src;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		o = track_item(f, a, pid, src);
		outcome_q.push_back(typed ? want : o);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		@(negedge clk) start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// APB write: setup then access, mirror updated once the transfer completes
	task automatic reg_write(logic [1:0] idx, logic [63:0] val);
		@(negedge clk) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= PADDR_W'({idx, 3'b000});
			pwdata <= val;
		end
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_OWN_PID:     own_pid_q = val[PID_W-1:0];
			REG_REGION_BASE: base_q = val[ADDR_W-1:0];
			REG_HOT_THR:     hot_thr_q = val[THR_W-1:0];
			default:         cool_thr_q = val[THR_W-1:0];
		endcase
		@(negedge clk) begin
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, request %0d page %0d",
					$realtime, request, request_page);
			end else begin
				want = outcome_q.pop_front();
				if (request !== want.request) begin
					errors++;
					$display("%0t: request expected %0d got %0d", $realtime,
						want.request, request);
				end
				if (request_page !== want.page) begin
					errors++;
					$display("%0t: request_page expected %0d got %0d", $realtime,
						want.page, request_page);
				end
				if (attributed !== want.attributed) begin
					errors++;
					$display("%0t: attributed expected %0b got %0b", $realtime,
						want.attributed, attributed);
				end
				if (cooled !== want.cooled) begin
					errors++;
					$display("%0t: cooled expected %0b got %0b", $realtime,
						want.cooled, cooled);
				end
				if (epoch !== want.epoch) begin
					errors++;
					$display("%0t: epoch expected %0d got %0d", $realtime,
						want.epoch, epoch);
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int            wp [WORK_PAGES];
		int            pick;
		int            pg;
		logic [1:0]    f;
		logic [ADDR_W-1:0] a;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = FN_SAMPLE;
		addr = '0;
		proc_id = '0;
		source = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed plan, reset settings first
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'h20_0000, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'h0, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h0, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'd1, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'd0, 1'b0, 1'b1,
			'{REQ_NONE, 12'd0, 1'b1, 1'b0, 32'd0}});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'hFFFF_FFFF_FFFF, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'h1_FFFF_FFFF, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h1_FFFF_FFFF, 22'd0, 1'b1, 1'b1,
			'{REQ_NONE, 12'd0, 1'b1, 1'b0, 32'd0}});
		plan.push_back('{ROW_ITEM, FN_DONE, 64'h20_0000, 22'd0, 1'b0, 1'b1, QUIET});
		plan.push_back('{ROW_ITEM, FN_REMOVE, 64'h40_0000, 22'd0, 1'b0, 1'b1, QUIET});
		// lowest thresholds, top process id
		plan.push_back('{ROW_CFG, REG_OWN_PID, 64'h3F_FFFF, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_CFG, REG_HOT_THR, 64'd1, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_CFG, REG_COOL_THR, 64'd1, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'h3F_FFFF, 1'b1, 1'b1,
			'{REQ_HOT, 12'd1, 1'b1, 1'b0, 32'd0}});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'h3F_FFFF, 1'b1, 1'b1,
			'{REQ_NONE, 12'd0, 1'b1, 1'b1, 32'd1}});
		plan.push_back('{ROW_ITEM, FN_DONE, 64'h20_0000, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_DONE, 64'h20_0000, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'h20_0000, 22'd0, 1'b0, 1'b0, QUIET});
		// highest thresholds: the hot page now asks to go cold
		plan.push_back('{ROW_CFG, REG_HOT_THR, 64'hFFFF, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_CFG, REG_COOL_THR, 64'hFFFF, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'h3F_FFFF, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_DONE, 64'h20_0000, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_REMOVE, 64'h20_0000, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h20_0000, 22'h3F_FFFF, 1'b0, 1'b0, QUIET});
		// region at the very top of the address space
		plan.push_back('{ROW_CFG, REG_REGION_BASE, 64'hFFFF_FFFF_FFFF, 22'd0, 1'b0, 1'b0,
			QUIET});
		plan.push_back('{ROW_ITEM, FN_REMOVE, 64'hFFFF_FFFF_FFFF, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'hFFFF_FFFF_FFFF, 22'd0, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'hFFFF_FFFF_FFFF, 22'h3F_FFFF, 1'b1, 1'b0,
			QUIET});
		plan.push_back('{ROW_ITEM, FN_SAMPLE, 64'h1000, 22'h3F_FFFF, 1'b0, 1'b0, QUIET});
		plan.push_back('{ROW_ITEM, FN_MAP, 64'h1000, 22'd0, 1'b0, 1'b0, QUIET});

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				reg_write(plan[i].code, plan[i].val);
			end else begin
				offer(plan[i].code, plan[i].val[ADDR_W-1:0], plan[i].pid, plan[i].src,
					plan[i].typed, plan[i].want);
			end
		end

		// random phases, each with fresh settings and a small working set
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			reg_write(REG_OWN_PID, (ph == 0) ? 64'd0 : 64'($urandom_range(0, 22'h3F_FFFF)));
			reg_write(REG_REGION_BASE, (ph == 2) ? 64'd0
				: {16'd0, 16'($urandom_range(0, 16'hFFFD)), 32'($urandom)});
			reg_write(REG_HOT_THR, (ph == 3) ? 64'd1 : (ph == 5) ? 64'hFFFF
				: 64'($urandom_range(1, 24)));
			reg_write(REG_COOL_THR, (ph == 4) ? 64'd1 : 64'($urandom_range(2, 40)));
			wp[0] = 0;
			wp[1] = NUM_PAGES - 1;
			for (int j = 2; j < WORK_PAGES; j++)
				wp[j] = $urandom_range(0, NUM_PAGES - 1);
			for (int j = 0; j < WORK_PAGES; j++)
				offer(FN_MAP, page_addr(wp[j], $urandom_range(0, 21'h1F_FFFF)), '0, 1'b0,
					1'b0, QUIET);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				pg = wp[$urandom_range(0, WORK_PAGES - 1)];
				a = page_addr(pg, $urandom_range(0, 21'h1F_FFFF));
				f = 2'($urandom_range(0, 3));
				if (pick < 62) begin
					offer(FN_SAMPLE, a, own_pid_q, 1'($urandom), 1'b0, QUIET);
				end else if (pick < 70) begin
					offer(FN_MAP, a, 22'($urandom), 1'($urandom), 1'b0, QUIET);
				end else if (pick < 75) begin
					offer(FN_REMOVE, a, 22'($urandom), 1'($urandom), 1'b0, QUIET);
				end else if (pick < 87) begin
					offer(FN_DONE, a, 22'($urandom), 1'($urandom), 1'b0, QUIET);
				end else if (pick < 90) begin
					// foreign process
					offer(FN_SAMPLE, a, 22'($urandom), 1'($urandom), 1'b0, QUIET);
				end else if (pick < 93) begin
					offer(f, {16'($urandom), 32'($urandom)}, 22'($urandom), 1'($urandom),
						1'b0, QUIET);
				end else if (pick < 96) begin
					// page index beyond the table
					offer(f, page_addr(NUM_PAGES + $urandom_range(0, 1000),
						$urandom_range(0, 21'h1F_FFFF)), own_pid_q, 1'($urandom), 1'b0, QUIET);
				end else if (pick < 98) begin
					// below the region
					offer(f, (base_q == '0) ? ADDR_W'($urandom) : base_q - 1
						- ADDR_W'($urandom_range(0, 4095)), own_pid_q, 1'($urandom), 1'b0, QUIET);
				end else begin
					offer(FN_SAMPLE, '0, own_pid_q, 1'($urandom), 1'b0, QUIET);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
